@@ hw/rtl/obbot_pkg.sv @@
// ----------------------------------------------------------------------------
// obbot_pkg: shared widths and types for the box pair overlap test
// Fixed-point widths for corners and projections, plus stage payload types.
// ----------------------------------------------------------------------------
package obbot_pkg;

  localparam int COORD_W  = 24;
  localparam int AFRAC    = 14;
  localparam int AXIS_W   = AFRAC + 2;
  localparam int EXT_W    = COORD_W - 1;
  // axis * extent product, signed
  localparam int PROD_W   = AXIS_W + EXT_W + 1;
  // corner = centre*2^AFRAC +- e1 +- e2
  localparam int CORN_W   = PROD_W + 3;
  // dot term corner * axis component
  localparam int TERM_W   = CORN_W + AXIS_W;
  localparam int PROJ_W   = TERM_W + 1;
  // pipeline register stages in the core
  localparam int NSTG     = 5;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [AXIS_W-1:0]  axis_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CORN_W-1:0]  corn_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [PROJ_W-1:0]  proj_t;

  typedef struct packed {
    axis_t c;
    axis_t s;
  } axis_pair_t;

  typedef struct packed {
    corn_t x;
    corn_t y;
  } corner_t;

endpackage

@@ hw/rtl/obbot_minmax.sv @@
// ----------------------------------------------------------------------------
// obbot_minmax: min and max of four projections
// Combinational two-level reduction on one axis for one box.
// ----------------------------------------------------------------------------
module obbot_minmax
  import obbot_pkg::*;
(
  input  proj_t p0,
  input  proj_t p1,
  input  proj_t p2,
  input  proj_t p3,
  output proj_t lo,
  output proj_t hi
);

  proj_t lo01, lo23, hi01, hi23;

  always_comb begin
    lo01 = (p1 < p0) ? p1 : p0;
    hi01 = (p1 > p0) ? p1 : p0;
    lo23 = (p3 < p2) ? p3 : p2;
    hi23 = (p3 > p2) ? p3 : p2;
    lo   = (lo23 < lo01) ? lo23 : lo01;
    hi   = (hi23 > hi01) ? hi23 : hi01;
  end

endmodule

@@ hw/rtl/obb_pair_overlap_test_core.sv @@
// ----------------------------------------------------------------------------
// obb_pair_overlap_test_core: separating-axis overlap test for two 2D boxes
// Forms each box's corners, projects them onto the four box axes and reports
// overlap (touching counts) for one box pair per word.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   input   | valid, ready, box_a_*, box_b_*  | in
//   result  | out_valid, out_ready, overlap   | out
//
// One word enters per cycle unless a stall on the result side holds the
// pipe; an accepted word raises out_valid once it reaches the last stage.
// Five register stages: extent products, corners, projection
// products, projection sums, and min/max together with the compare.
// Reset clears only the stage valid bits. A stall on the result side holds
// each full stage with no empty stage below it; empty stages still fill (bubbles collapse).
// ----------------------------------------------------------------------------
module obb_pair_overlap_test_core
  import obbot_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                ready,
  input  logic signed [23:0]  box_a_centre_x,
  input  logic signed [23:0]  box_a_centre_y,
  input  logic signed [15:0]  box_a_axis_cos,
  input  logic signed [15:0]  box_a_axis_sin,
  input  logic [22:0]         box_a_half_width,
  input  logic [22:0]         box_a_half_height,
  input  logic signed [23:0]  box_b_centre_x,
  input  logic signed [23:0]  box_b_centre_y,
  input  logic signed [15:0]  box_b_axis_cos,
  input  logic signed [15:0]  box_b_axis_sin,
  input  logic [22:0]         box_b_half_width,
  input  logic [22:0]         box_b_half_height,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                overlap
);

  // stage valid bits and per-stage advance enables
  logic [NSTG-1:0] v;
  logic [NSTG-1:0] adv;

  // a stage moves when downstream takes its word or it is empty
  always_comb begin
    adv[NSTG-1] = !v[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign ready     = adv[0];
  assign out_valid = v[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= valid;
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) v[i] <= v[i-1];
      end
    end
  end

  // ---- stage 1: extent products, scaled centres ---------------------------
  axis_pair_t ax1 [2];
  prod_t      e1x [2], e1y [2], e2x [2], e2y [2];
  corn_t      px1 [2], py1 [2];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      ax1[0] <= '{c: box_a_axis_cos, s: box_a_axis_sin};
      ax1[1] <= '{c: box_b_axis_cos, s: box_b_axis_sin};
      e1x[0] <= PROD_W'(box_a_axis_cos * $signed({1'b0, box_a_half_width}));
      e1y[0] <= PROD_W'(box_a_axis_sin * $signed({1'b0, box_a_half_width}));
      e2x[0] <= PROD_W'(-(PROD_W'(box_a_axis_sin))
                        * $signed({1'b0, box_a_half_height}));
      e2y[0] <= PROD_W'(box_a_axis_cos * $signed({1'b0, box_a_half_height}));
      e1x[1] <= PROD_W'(box_b_axis_cos * $signed({1'b0, box_b_half_width}));
      e1y[1] <= PROD_W'(box_b_axis_sin * $signed({1'b0, box_b_half_width}));
      e2x[1] <= PROD_W'(-(PROD_W'(box_b_axis_sin))
                        * $signed({1'b0, box_b_half_height}));
      e2y[1] <= PROD_W'(box_b_axis_cos * $signed({1'b0, box_b_half_height}));
      px1[0] <= CORN_W'(box_a_centre_x) <<< AFRAC;
      py1[0] <= CORN_W'(box_a_centre_y) <<< AFRAC;
      px1[1] <= CORN_W'(box_b_centre_x) <<< AFRAC;
      py1[1] <= CORN_W'(box_b_centre_y) <<< AFRAC;
    end
  end

  // ---- stage 2: corners ---------------------------------------------------
  axis_pair_t ax2 [2];
  corner_t    cr2 [2][4];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int b = 0; b < 2; b++) begin
        ax2[b] <= ax1[b];
        cr2[b][0].x <= px1[b] + CORN_W'(e1x[b]) + CORN_W'(e2x[b]);
        cr2[b][0].y <= py1[b] + CORN_W'(e1y[b]) + CORN_W'(e2y[b]);
        cr2[b][1].x <= px1[b] + CORN_W'(e1x[b]) - CORN_W'(e2x[b]);
        cr2[b][1].y <= py1[b] + CORN_W'(e1y[b]) - CORN_W'(e2y[b]);
        cr2[b][2].x <= px1[b] - CORN_W'(e1x[b]) - CORN_W'(e2x[b]);
        cr2[b][2].y <= py1[b] - CORN_W'(e1y[b]) - CORN_W'(e2y[b]);
        cr2[b][3].x <= px1[b] - CORN_W'(e1x[b]) + CORN_W'(e2x[b]);
        cr2[b][3].y <= py1[b] - CORN_W'(e1y[b]) + CORN_W'(e2y[b]);
      end
    end
  end

  // ---- stage 3: dot product terms, axis k, box b, corner j ----------------
  // axis 0/1 from box a, 2/3 from box b; axis 1 = (-s, c)
  term_t tx3 [4][2][4], ty3 [4][2][4];

  // negate the product, not the axis code, so the raw -32768 cannot wrap
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int k = 0; k < 4; k++) begin
        for (int b = 0; b < 2; b++) begin
          for (int j = 0; j < 4; j++) begin
            if (k % 2 == 1) begin
              tx3[k][b][j] <= -(TERM_W'(cr2[b][j].x * ax2[k/2].s));
              ty3[k][b][j] <= TERM_W'(cr2[b][j].y * ax2[k/2].c);
            end else begin
              tx3[k][b][j] <= TERM_W'(cr2[b][j].x * ax2[k/2].c);
              ty3[k][b][j] <= TERM_W'(cr2[b][j].y * ax2[k/2].s);
            end
          end
        end
      end
    end
  end

  // ---- stage 4: projections -----------------------------------------------
  proj_t pr4 [4][2][4];

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int k = 0; k < 4; k++) begin
        for (int b = 0; b < 2; b++) begin
          for (int j = 0; j < 4; j++) begin
            pr4[k][b][j] <= PROJ_W'(tx3[k][b][j]) + PROJ_W'(ty3[k][b][j]);
          end
        end
      end
    end
  end

  // ---- stage 5: min/max per axis and box, separation compare -------------
  proj_t lo [4][2], hi [4][2];
  logic [3:0] sep;

  for (genvar k = 0; k < 4; k++) begin : g_ax
    for (genvar b = 0; b < 2; b++) begin : g_bx
      obbot_minmax u_mm (
        .p0(pr4[k][b][0]), .p1(pr4[k][b][1]),
        .p2(pr4[k][b][2]), .p3(pr4[k][b][3]),
        .lo(lo[k][b]), .hi(hi[k][b])
      );
    end
    assign sep[k] = (lo[k][0] > hi[k][1]) || (lo[k][1] > hi[k][0]);
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      overlap <= ~|sep;
    end
  end

  // ---- checks -------------------------------------------------------------
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(overlap))
    else $error("result word changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> ready)
    else $error("input blocked with empty output stage");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    valid && ready |=> v[0])
    else $error("accepted word not captured");

endmodule
